[rtl/ohm_pkg.sv]
// shared constants, codes and types for the ordered hash map engine
package ohm_pkg;

    localparam int BUCKETS     = 64;
    localparam int ENTRY_SLOTS = 64;
    localparam int MAX_RESULTS = 64;

    localparam int BKT_W  = $clog2(BUCKETS);
    localparam int EA_W   = $clog2(ENTRY_SLOTS);
    localparam int SLOT_W = $clog2(ENTRY_SLOTS + 2);
    localparam int CNT_W  = $clog2(ENTRY_SLOTS + 1);
    localparam int LIM_W  = 7;
    localparam int STS_W  = 3;
    localparam int FN_W   = 3;

    localparam logic [SLOT_W-1:0] CODE_EMPTY = SLOT_W'(ENTRY_SLOTS);
    localparam logic [SLOT_W-1:0] CODE_TOMB  = SLOT_W'(ENTRY_SLOTS + 1);

    localparam logic [63:0] MINUS_ZERO = 64'h8000_0000_0000_0000;
    localparam logic [63:0] HASH_C1    = 64'hff51_afd7_ed55_8ccd;
    localparam logic [63:0] HASH_C2    = 64'hc4ce_b9fe_1a85_ec53;
    localparam int          HASH_SH    = 33;

    localparam logic [LIM_W-1:0] LIMIT_RST = 7'd48;

    localparam logic [FN_W-1:0] F_SET  = 3'd0;
    localparam logic [FN_W-1:0] F_GET  = 3'd1;
    localparam logic [FN_W-1:0] F_DEL  = 3'd2;
    localparam logic [FN_W-1:0] F_CLR  = 3'd3;
    localparam logic [FN_W-1:0] F_WALK = 3'd4;

    localparam logic [STS_W-1:0] ST_OK     = 3'd0;
    localparam logic [STS_W-1:0] ST_INS    = 3'd1;
    localparam logic [STS_W-1:0] ST_ABSENT = 3'd2;
    localparam logic [STS_W-1:0] ST_FULL   = 3'd3;
    localparam logic [STS_W-1:0] ST_EMPTY  = 3'd4;

    typedef struct packed {
        logic        start;
        logic [63:0] key;
    } t_hash_req;

    typedef struct packed {
        logic             done;
        logic [BKT_W-1:0] bucket;
    } t_hash_rsp;

endpackage

[rtl/ohm_ram.sv]
// generic single-port-write, single-port-read ram with registered read
module ohm_ram #(
    parameter int W = 8,
    parameter int D = 64
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/ohm_hash.sv]
// sequential mix-shift-multiply hash on one shared 32x32 multiplier
module ohm_hash (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ohm_pkg::t_hash_req i_req,
    output ohm_pkg::t_hash_rsp o_rsp
);
    import ohm_pkg::*;

    logic [63:0]      r_a;
    logic [63:0]      r_acc;
    logic [63:0]      r_prod;
    logic [1:0]       r_step;
    logic             r_pass;
    logic             r_busy;
    logic             r_done;
    logic [BKT_W-1:0] r_bkt;

    logic [63:0] c;
    logic [31:0] a_part;
    logic [31:0] c_part;
    logic [63:0] prod;
    logic [63:0] sum;
    logic [63:0] mixed;

    always_comb begin
        c      = r_pass ? HASH_C2 : HASH_C1;
        a_part = (r_step == 2'd1) ? r_a[63:32] : r_a[31:0];
        c_part = (r_step == 2'd2) ? c[63:32] : c[31:0];
        prod   = a_part * c_part;
        sum    = r_acc + {r_prod[31:0], 32'h0};
        mixed  = sum ^ (sum >> HASH_SH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_a    <= i_req.key ^ (i_req.key >> HASH_SH);
                r_pass <= 1'b0;
                r_step <= 2'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_prod <= prod;
                unique case (r_step)
                    2'd0: begin
                        r_step <= 2'd1;
                    end
                    2'd1: begin
                        r_acc  <= r_prod;
                        r_step <= 2'd2;
                    end
                    2'd2: begin
                        r_acc  <= sum;
                        r_step <= 2'd3;
                    end
                    2'd3: begin
                        r_step <= 2'd0;
                        if (!r_pass) begin
                            r_a    <= mixed;
                            r_pass <= 1'b1;
                        end else begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                            r_bkt  <= mixed[BKT_W-1:0];
                        end
                    end
                endcase
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.bucket = r_bkt;

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_done |-> !r_busy)
        else $error("hash done while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_done |-> $past(r_busy))
        else $error("hash done without work");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_step == 2'd3 && r_pass) |=> r_done)
        else $error("hash finish lost");

endmodule

[rtl/ordered_hash_map_engine_top.sv]
// ordered hash map engine: probe sequencer over bucket and entry memories
// set, get, delete: hash on the one multiplier, then a linear probe from the hashed bucket
// skipping tombstones and comparing keys in occupied buckets; insert then adds the entry
// clear and unused codes: direct result; walk: entries in list order while the sink keeps up
// one item at a time; the output register lets the next item in while a result waits
// reset is synchronous active low: bucket valid bits, order list, counts and load limit
// (48) are set at once; entry memories are not swept, so no clearing pass is needed
module ordered_hash_map_engine_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [ohm_pkg::LIM_W-1:0] i_cfg_wdata,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [127:0]              i_s_tdata,  // key, value
    input  logic [ohm_pkg::FN_W-1:0]  i_s_tuser,  // func
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [135:0]              o_m_tdata,  // out_key, out_value, live_count, zero pad
    output logic [ohm_pkg::STS_W-1:0] o_m_tuser,  // status
    output logic                      o_m_tlast
);
    import ohm_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_HASH  = 4'd1;
    localparam logic [3:0] S_BCHK  = 4'd2;
    localparam logic [3:0] S_KCHK  = 4'd3;
    localparam logic [3:0] S_MISS  = 4'd4;
    localparam logic [3:0] S_INS   = 4'd5;
    localparam logic [3:0] S_INS2  = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;
    localparam logic [3:0] S_WDATA = 4'd8;

    logic [3:0]         r_state;
    logic [FN_W-1:0]    r_func;
    logic [63:0]        r_key;
    logic [63:0]        r_val;
    logic [BKT_W-1:0]   r_bkt;
    logic [BKT_W-1:0]   r_probe;
    logic [BKT_W-1:0]   r_free;
    logic               r_free_vld;
    logic [SLOT_W-1:0]  r_e;
    logic [SLOT_W-1:0]  r_slot;
    logic [SLOT_W-1:0]  r_head;
    logic [SLOT_W-1:0]  r_tail;
    logic [CNT_W-1:0]   r_live;
    logic [CNT_W-1:0]   r_slots;
    logic [CNT_W-1:0]   r_n;
    logic [LIM_W-1:0]   r_limit;
    logic [BUCKETS-1:0] r_bval;
    logic               r_bv;
    logic               r_walk;
    logic [STS_W-1:0]   r_res_st;
    logic [63:0]        r_res_key;
    logic [63:0]        r_res_val;
    logic               r_res_last;
    logic               r_ovld;
    logic [STS_W-1:0]   r_ost;
    logic [63:0]        r_okey;
    logic [63:0]        r_oval;
    logic [CNT_W-1:0]   r_olive;
    logic               r_olast;

    t_hash_req hreq;
    t_hash_rsp hrsp;

    logic [BKT_W-1:0]  b_raddr;
    logic              b_we;
    logic [BKT_W-1:0]  b_waddr;
    logic [SLOT_W-1:0] b_wdata;
    logic [SLOT_W-1:0] b_rdata;
    logic [EA_W-1:0]   e_raddr;
    logic              k_we;
    logic              v_we;
    logic [EA_W-1:0]   v_waddr;
    logic              p_we;
    logic [EA_W-1:0]   p_waddr;
    logic [SLOT_W-1:0] p_wdata;
    logic              nx_we;
    logic [EA_W-1:0]   nx_waddr;
    logic [SLOT_W-1:0] nx_wdata;
    logic [63:0]       k_rdata;
    logic [63:0]       v_rdata;
    logic [SLOT_W-1:0] p_rdata;
    logic [SLOT_W-1:0] n_rdata;

    logic              s_acc;
    logic              out_free;
    logic [63:0]       in_key;
    logic [SLOT_W-1:0] bkt_e;
    logic              key_hit;
    logic              at_end;
    logic [BKT_W-1:0]  next_bkt;
    logic              can_ins;
    logic [SLOT_W-1:0] new_slot;
    logic              del_hit;

    function automatic logic is_entry(input logic [SLOT_W-1:0] code);
        is_entry = code < SLOT_W'(ENTRY_SLOTS);
    endfunction

    assign s_acc    = i_s_tvalid && o_s_tready;
    assign out_free = !r_ovld || i_m_tready;
    assign in_key   = (i_s_tdata[63:0] == MINUS_ZERO) ? 64'h0 : i_s_tdata[63:0];
    assign bkt_e    = r_bv ? b_rdata : CODE_EMPTY;
    assign key_hit  = k_rdata == r_key;
    assign at_end   = r_probe == BKT_W'(BUCKETS - 1);
    assign next_bkt = r_bkt + 1'b1;
    assign new_slot = SLOT_W'(r_slots);
    assign can_ins  = (16'(r_live) < 16'(r_limit)) && (r_slots != CNT_W'(ENTRY_SLOTS))
                      && r_free_vld;
    assign del_hit  = (r_state == S_KCHK) && key_hit && (r_func == F_DEL);

    assign hreq.start = s_acc && (i_s_tuser == F_SET || i_s_tuser == F_GET
                                  || i_s_tuser == F_DEL);
    assign hreq.key   = in_key;

    always_comb begin
        b_raddr  = next_bkt;
        e_raddr  = r_e[EA_W-1:0];
        b_we     = 1'b0;
        b_waddr  = r_bkt;
        b_wdata  = CODE_TOMB;
        k_we     = 1'b0;
        v_we     = 1'b0;
        v_waddr  = new_slot[EA_W-1:0];
        p_we     = 1'b0;
        p_waddr  = new_slot[EA_W-1:0];
        p_wdata  = r_tail;
        nx_we    = 1'b0;
        nx_waddr = new_slot[EA_W-1:0];
        nx_wdata = CODE_EMPTY;
        unique case (r_state)
            S_IDLE: begin
                e_raddr = r_head[EA_W-1:0];
            end
            S_HASH: begin
                b_raddr = hrsp.bucket;
            end
            S_BCHK: begin
                e_raddr = bkt_e[EA_W-1:0];
            end
            S_KCHK: begin
                if (key_hit && r_func == F_SET) begin
                    v_we    = 1'b1;
                    v_waddr = r_e[EA_W-1:0];
                end
                if (del_hit) begin
                    b_we     = 1'b1;
                    p_we     = is_entry(n_rdata);
                    p_waddr  = n_rdata[EA_W-1:0];
                    p_wdata  = p_rdata;
                    nx_we    = is_entry(p_rdata);
                    nx_waddr = p_rdata[EA_W-1:0];
                    nx_wdata = n_rdata;
                end
            end
            S_INS: begin
                b_we    = 1'b1;
                b_waddr = r_free;
                b_wdata = new_slot;
                k_we    = 1'b1;
                v_we    = 1'b1;
                p_we    = 1'b1;
                nx_we   = 1'b1;
            end
            S_INS2: begin
                nx_we    = 1'b1;
                nx_waddr = r_e[EA_W-1:0];
                nx_wdata = r_slot;
            end
            S_MISS, S_OUT, S_WDATA: begin
            end
            default: begin
            end
        endcase
    end

    ohm_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (hreq),
        .o_rsp   (hrsp)
    );

    ohm_ram #(.W(SLOT_W), .D(BUCKETS)) u_bucket (
        .i_clk(i_clk), .i_we(b_we), .i_waddr(b_waddr), .i_wdata(b_wdata),
        .i_raddr(b_raddr), .o_rdata(b_rdata)
    );

    ohm_ram #(.W(64), .D(ENTRY_SLOTS)) u_keys (
        .i_clk(i_clk), .i_we(k_we), .i_waddr(new_slot[EA_W-1:0]), .i_wdata(r_key),
        .i_raddr(e_raddr), .o_rdata(k_rdata)
    );

    ohm_ram #(.W(64), .D(ENTRY_SLOTS)) u_vals (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_waddr), .i_wdata(r_val),
        .i_raddr(e_raddr), .o_rdata(v_rdata)
    );

    ohm_ram #(.W(SLOT_W), .D(ENTRY_SLOTS)) u_prev (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_waddr), .i_wdata(p_wdata),
        .i_raddr(e_raddr), .o_rdata(p_rdata)
    );

    ohm_ram #(.W(SLOT_W), .D(ENTRY_SLOTS)) u_next (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_waddr), .i_wdata(nx_wdata),
        .i_raddr(e_raddr), .o_rdata(n_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_limit <= LIMIT_RST;
            r_bval  <= '0;
            r_head  <= CODE_EMPTY;
            r_tail  <= CODE_EMPTY;
            r_live  <= '0;
            r_slots <= '0;
            r_ovld  <= 1'b0;
            r_walk  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (r_state == S_OUT && out_free) begin
                r_ovld <= 1'b1;
            end else if (i_m_tready) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_func     <= i_s_tuser;
                        r_key      <= in_key;
                        r_val      <= i_s_tdata[127:64];
                        r_res_key  <= '0;
                        r_res_val  <= '0;
                        r_res_last <= 1'b1;
                        r_walk     <= (i_s_tuser == F_WALK) && is_entry(r_head);
                        unique case (i_s_tuser)
                            F_SET, F_GET, F_DEL: begin
                                r_state <= S_HASH;
                            end
                            F_CLR: begin
                                r_bval   <= '0;
                                r_head   <= CODE_EMPTY;
                                r_tail   <= CODE_EMPTY;
                                r_live   <= '0;
                                r_slots  <= '0;
                                r_res_st <= ST_OK;
                                r_state  <= S_OUT;
                            end
                            F_WALK: begin
                                if (is_entry(r_head)) begin
                                    r_e     <= r_head;
                                    r_n     <= '0;
                                    r_state <= S_WDATA;
                                end else begin
                                    r_res_st <= ST_EMPTY;
                                    r_state  <= S_OUT;
                                end
                            end
                            default: begin
                                r_res_st <= ST_ABSENT;
                                r_state  <= S_OUT;
                            end
                        endcase
                    end
                end
                S_HASH: begin
                    if (hrsp.done) begin
                        r_bkt      <= hrsp.bucket;
                        r_probe    <= '0;
                        r_free_vld <= 1'b0;
                        r_bv       <= r_bval[hrsp.bucket];
                        r_state    <= S_BCHK;
                    end
                end
                S_BCHK: begin
                    if (bkt_e == CODE_EMPTY || bkt_e == CODE_TOMB) begin
                        if (!r_free_vld) begin
                            r_free     <= r_bkt;
                            r_free_vld <= 1'b1;
                        end
                        if (bkt_e == CODE_EMPTY || at_end) begin
                            r_state <= S_MISS;
                        end else begin
                            r_bkt   <= next_bkt;
                            r_probe <= r_probe + 1'b1;
                            r_bv    <= r_bval[next_bkt];
                        end
                    end else begin
                        r_e     <= bkt_e;
                        r_state <= S_KCHK;
                    end
                end
                S_KCHK: begin
                    if (key_hit) begin
                        r_res_st <= ST_OK;
                        if (r_func == F_GET) begin
                            r_res_val <= v_rdata;
                        end
                        if (del_hit) begin
                            if (!is_entry(p_rdata)) begin
                                r_head <= n_rdata;
                            end
                            if (!is_entry(n_rdata)) begin
                                r_tail <= p_rdata;
                            end
                            if (r_live != '0) begin
                                r_live <= r_live - 1'b1;
                            end
                        end
                        r_state <= S_OUT;
                    end else if (at_end) begin
                        r_state <= S_MISS;
                    end else begin
                        r_bkt   <= next_bkt;
                        r_probe <= r_probe + 1'b1;
                        r_bv    <= r_bval[next_bkt];
                        r_state <= S_BCHK;
                    end
                end
                S_MISS: begin
                    if (r_func != F_SET) begin
                        r_res_st <= ST_ABSENT;
                        r_state  <= S_OUT;
                    end else if (can_ins) begin
                        r_res_st <= ST_INS;
                        r_state  <= S_INS;
                    end else begin
                        r_res_st <= ST_FULL;
                        r_state  <= S_OUT;
                    end
                end
                S_INS: begin
                    r_bval[r_free] <= 1'b1;
                    r_slots        <= r_slots + 1'b1;
                    r_live         <= r_live + 1'b1;
                    r_tail         <= new_slot;
                    r_slot         <= new_slot;
                    r_e            <= r_tail;
                    if (r_head == CODE_EMPTY) begin
                        r_head <= new_slot;
                    end
                    r_state <= is_entry(r_tail) ? S_INS2 : S_OUT;
                end
                S_INS2: begin
                    r_state <= S_OUT;
                end
                S_WDATA: begin
                    r_res_st   <= ST_OK;
                    r_res_key  <= k_rdata;
                    r_res_val  <= v_rdata;
                    r_res_last <= !is_entry(n_rdata) || (r_n == CNT_W'(MAX_RESULTS - 1));
                    r_e        <= n_rdata;
                    r_state    <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_ost   <= r_res_st;
                        r_okey  <= r_res_key;
                        r_oval  <= r_res_val;
                        r_olive <= r_live;
                        r_olast <= r_res_last;
                        if (r_walk && !r_res_last) begin
                            r_n     <= r_n + 1'b1;
                            r_state <= S_WDATA;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = r_state == S_IDLE;
    assign o_m_tvalid = r_ovld;
    assign o_m_tdata  = {1'b0, 7'(r_olive), r_oval, r_okey};
    assign o_m_tuser  = r_ost;
    assign o_m_tlast  = r_olast;

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_live <= r_slots)
        else $error("more live entries than slots used");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == CODE_EMPTY) == (r_tail == CODE_EMPTY))
        else $error("order list ends disagree");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == CODE_EMPTY) |-> (r_live == '0))
        else $error("live entries with empty order list");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS2) |-> ($past(r_state) == S_INS))
        else $error("link update outside insert");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS) |-> (r_free_vld && r_func == F_SET))
        else $error("insert without free bucket");

endmodule

[test/ordered_hash_map_engine_top_tb.sv]
// testbench for the ordered hash map engine: queued stream driver, checking monitor, predictor
`timescale 1ns / 1ps

module ordered_hash_map_engine_top_tb;
    import ohm_pkg::*;

    localparam logic [FN_W-1:0] F_SPARE5 = 3'd5;
    localparam logic [FN_W-1:0] F_SPARE6 = 3'd6;
    localparam logic [FN_W-1:0] F_SPARE7 = 3'd7;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 30;

    typedef struct packed {
        logic [FN_W-1:0] fn;
        logic [63:0]     key;
        logic [63:0]     val;
    } t_map_op;

    typedef struct packed {
        logic [STS_W-1:0] st;
        logic [63:0]      k;
        logic [63:0]      v;
        logic [6:0]       cnt;
        logic             last;
    } t_map_res;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [LIM_W-1:0]  i_cfg_wdata = '0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [127:0]      i_s_tdata = '0;
    logic [FN_W-1:0]   i_s_tuser = '0;
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [135:0]      o_m_tdata;
    logic [STS_W-1:0]  o_m_tuser;
    logic              o_m_tlast;

    ordered_hash_map_engine_top DUT (.*);

    always #4 i_clk = ~i_clk;

    t_map_op  op_q[$];
    t_map_res result_q[$];
    int       errors = 0;
    bit       hold_req = 1'b0;

    // predicted map state
    logic [6:0]  bkt[BUCKETS];
    logic [63:0] ekey[ENTRY_SLOTS];
    logic [63:0] eval[ENTRY_SLOTS];
    logic        elive[ENTRY_SLOTS];
    logic [6:0]  eprev[ENTRY_SLOTS];
    logic [6:0]  enext[ENTRY_SLOTS];
    logic [6:0]  head, tail;
    int          live, used;
    logic [6:0]  limit;

    task automatic report(string what);
        errors++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    function automatic logic [5:0] bucket_of(logic [63:0] k);
        k ^= k >> HASH_SH;
        k = k * HASH_C1;
        k ^= k >> HASH_SH;
        k = k * HASH_C2;
        k ^= k >> HASH_SH;
        return k[5:0];
    endfunction

    function automatic int find_key(logic [63:0] k);
        int b;
        logic [5:0] h;
        h = bucket_of(k);
        for (int p = 0; p < BUCKETS; p++) begin
            b = (h + p) % BUCKETS;
            if (bkt[b] == CODE_EMPTY) return -1;
            if (bkt[b] < ENTRY_SLOTS && elive[bkt[b]] && ekey[bkt[b]] == k) return b;
        end
        return -1;
    endfunction

    task automatic wipe_map();
        for (int i = 0; i < BUCKETS; i++) bkt[i] = CODE_EMPTY;
        for (int i = 0; i < ENTRY_SLOTS; i++) elive[i] = 1'b0;
        head = CODE_EMPTY;
        tail = CODE_EMPTY;
        live = 0;
        used = 0;
    endtask

    task automatic add_result(logic [STS_W-1:0] st, logic [63:0] k, logic [63:0] v);
        t_map_res r;
        r.st = st; r.k = k; r.v = v; r.cnt = live[6:0]; r.last = 1'b0;
        result_q = {result_q, r};
    endtask

    task automatic predict_op(t_map_op op);
        logic [63:0] k;
        logic [5:0]  h;
        int b, fb, n, e, steps, slot, pv, nx;
        t_map_res r;
        k = (op.key == MINUS_ZERO) ? 64'd0 : op.key;
        n = 0;
        case (op.fn)
            F_SET: begin
                b = find_key(k);
                if (b >= 0) begin
                    eval[bkt[b]] = op.val;
                    add_result(ST_OK, 0, 0);
                end else if (live >= limit || used >= ENTRY_SLOTS) begin
                    add_result(ST_FULL, 0, 0);
                end else begin
                    fb = -1;
                    h = bucket_of(k);
                    for (int p = 0; p < BUCKETS; p++)
                        if (fb < 0 && bkt[(h + p) % BUCKETS] >= ENTRY_SLOTS)
                            fb = (h + p) % BUCKETS;
                    if (fb < 0) begin
                        add_result(ST_FULL, 0, 0);
                    end else begin
                        slot = used++;
                        ekey[slot] = k;
                        eval[slot] = op.val;
                        elive[slot] = 1'b1;
                        eprev[slot] = tail;
                        enext[slot] = CODE_EMPTY;
                        if (tail < ENTRY_SLOTS) enext[tail] = slot[6:0];
                        tail = slot[6:0];
                        if (head == CODE_EMPTY) head = slot[6:0];
                        bkt[fb] = slot[6:0];
                        live++;
                        add_result(ST_INS, 0, 0);
                    end
                end
            end
            F_GET: begin
                b = find_key(k);
                if (b >= 0) add_result(ST_OK, 0, eval[bkt[b]]);
                else add_result(ST_ABSENT, 0, 0);
            end
            F_DEL: begin
                b = find_key(k);
                if (b < 0) begin
                    add_result(ST_ABSENT, 0, 0);
                end else begin
                    e = bkt[b];
                    pv = eprev[e];
                    nx = enext[e];
                    if (pv < ENTRY_SLOTS) enext[pv] = nx[6:0]; else head = nx[6:0];
                    if (nx < ENTRY_SLOTS) eprev[nx] = pv[6:0]; else tail = pv[6:0];
                    elive[e] = 1'b0;
                    bkt[b] = CODE_TOMB;
                    if (live > 0) live--;
                    add_result(ST_OK, 0, 0);
                end
            end
            F_CLR: begin
                wipe_map();
                add_result(ST_OK, 0, 0);
            end
            F_WALK: begin
                e = head;
                steps = 0;
                while (e < ENTRY_SLOTS && n < MAX_RESULTS && steps < ENTRY_SLOTS) begin
                    if (elive[e]) begin
                        add_result(ST_OK, ekey[e], eval[e]);
                        n++;
                    end
                    e = enext[e];
                    steps++;
                end
                if (n == 0) add_result(ST_EMPTY, 0, 0);
            end
            default: add_result(ST_ABSENT, 0, 0);
        endcase
        r = result_q.pop_back();
        r.last = 1'b1;
        result_q = {result_q, r};
    endtask

    // driver
    int  send_gap = 0;
    bit  send_burst = 1'b0;
    always @(posedge i_clk) begin
        t_map_op op;
        logic    v;
        v = i_s_tvalid;
        if (i_s_tvalid && o_s_tready) begin
            predict_op({i_s_tuser, i_s_tdata[63:0], i_s_tdata[127:64]});
            v = 1'b0;
            if ($urandom_range(0, 15) == 0) send_burst = ~send_burst;
            send_gap = send_burst ? 0 : $urandom_range(0, 12);
        end
        if (!i_rst_n) begin
            v = 1'b0;
        end else if (!v) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (op_q.size() > 0) begin
                op = op_q.pop_front();
                i_s_tuser <= op.fn;
                i_s_tdata <= {op.val, op.key};
                v = 1'b1;
            end
        end
        i_s_tvalid <= v;
    end

    // monitor
    int  recv_gap = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  recv_burst = 1'b0;
    always @(posedge i_clk) begin
        t_map_res exp_r;
        logic     r;
        r = i_m_tready;
        if (o_m_tvalid && i_m_tready) begin
            if (result_q.size() == 0) begin
                report("result transfer with nothing expected");
            end else begin
                exp_r = result_q.pop_front();
                if (o_m_tuser !== exp_r.st)
                    report($sformatf("status %0d, want %0d", o_m_tuser, exp_r.st));
                if (o_m_tdata[63:0] !== exp_r.k)
                    report($sformatf("out_key %h, want %h", o_m_tdata[63:0], exp_r.k));
                if (o_m_tdata[127:64] !== exp_r.v)
                    report($sformatf("out_value %h, want %h", o_m_tdata[127:64], exp_r.v));
                if (o_m_tdata[134:128] !== exp_r.cnt)
                    report($sformatf("live_count %0d, want %0d",
                                     o_m_tdata[134:128], exp_r.cnt));
                if (o_m_tlast !== exp_r.last)
                    report($sformatf("last %b, want %b", o_m_tlast, exp_r.last));
            end
            if ($urandom_range(0, 15) == 0) recv_burst = ~recv_burst;
            recv_gap = recv_burst ? 0 : $urandom_range(0, 12);
            r = (recv_gap == 0);
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            r = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            r = 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            r = (recv_gap == 0);
        end else begin
            r = 1'b1;
        end
        i_m_tready <= i_rst_n ? r : 1'b0;
    end

    // watchdog
    int quiet = 0;
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || !i_rst_n)
            quiet = 0;
        else if (op_q.size() > 0 || result_q.size() > 0 || i_s_tvalid)
            quiet++;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("ordered_hash_map_engine_top_tb: done, errors");
            $finish;
        end
    end

    logic [63:0] key_pool[24];

    task automatic push_op(logic [FN_W-1:0] fn, logic [63:0] key, logic [63:0] val);
        t_map_op op;
        op.fn  = fn;
        op.key = key;
        op.val = val;
        op_q = {op_q, op};
    endtask

    task automatic wait_idle();
        @(posedge i_clk);
        while (op_q.size() > 0 || i_s_tvalid || result_q.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [6:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        limit = v;
        @(posedge i_clk);
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic random_ops(int count);
        int pick;
        logic [63:0] k;
        logic [FN_W-1:0] fn;
        for (int i = 0; i < count; i++) begin
            k = ($urandom_range(0, 9) == 0) ? rnd64() : key_pool[$urandom_range(0, 23)];
            pick = $urandom_range(0, 99);
            if (pick < 42) fn = F_SET;
            else if (pick < 66) fn = F_GET;
            else if (pick < 86) fn = F_DEL;
            else if (pick < 94) fn = F_WALK;
            else if (pick < 96) fn = F_CLR;
            else if (pick < 97) fn = F_SPARE5;
            else if (pick < 98) fn = F_SPARE6;
            else fn = F_SPARE7;
            push_op(fn, k, rnd64());
        end
    endtask

    initial begin
        limit = LIMIT_RST;
        wipe_map();
        for (int i = 0; i < 24; i++) key_pool[i] = rnd64();
        key_pool[0] = 64'd0;
        key_pool[1] = MINUS_ZERO;
        key_pool[2] = '1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty walk, spare codes, zero and minus zero, extremes
        push_op(F_WALK, 0, 0);
        push_op(F_SPARE5, '1, '1);
        push_op(F_SPARE6, 0, 0);
        push_op(F_SPARE7, MINUS_ZERO, 1);
        push_op(F_GET, 64'h1234, 0);
        push_op(F_DEL, 64'h1234, 0);
        push_op(F_SET, 0, 64'h1111);
        push_op(F_SET, MINUS_ZERO, 64'h2222);
        push_op(F_GET, 0, 0);
        push_op(F_SET, '1, '1);
        push_op(F_SET, 64'h5555_aaaa_5555_aaaa, 0);
        push_op(F_GET, '1, 0);
        push_op(F_WALK, 0, 0);
        push_op(F_DEL, MINUS_ZERO, 0);
        push_op(F_GET, 0, 0);
        push_op(F_WALK, 0, 0);
        push_op(F_CLR, 0, 0);
        push_op(F_WALK, 0, 0);
        wait_idle();

        // smallest nonzero limit
        write_limit(7'd1);
        push_op(F_SET, 64'h10, 64'h1);
        push_op(F_SET, 64'h20, 64'h2);
        push_op(F_SET, 64'h10, 64'h3);
        push_op(F_GET, 64'h10, 0);
        wait_idle();

        // largest effective limit: fill every slot and bucket, then run out of slots
        write_limit(7'd64);
        push_op(F_CLR, 0, 0);
        for (int i = 0; i < 64; i++) push_op(F_SET, rnd64(), rnd64());
        push_op(F_SET, 64'h77, 0);
        push_op(F_GET, 64'h99, 0);
        push_op(F_WALK, 0, 0);
        for (int i = 0; i < 3; i++) push_op(F_DEL, op_q[1 + i * 7].key, 0);
        push_op(F_SET, 64'h88, 0);
        push_op(F_WALK, 0, 0);
        push_op(F_CLR, 0, 0);
        wait_idle();

        write_limit(LIMIT_RST);
        random_ops(80);
        hold_req = 1'b1;
        wait_idle();
        write_limit(7'($urandom_range(2, 12)));
        random_ops(80);
        wait_idle();
        write_limit(7'd64);
        random_ops(74);
        wait_idle();
        write_limit(7'($urandom_range(1, 64)));
        random_ops(80);
        wait_idle();

        if (errors == 0)
            $display("ordered_hash_map_engine_top_tb: done, clean");
        else
            $display("ordered_hash_map_engine_top_tb: done, errors");
        $finish;
    end

endmodule

[sim.f]
rtl/ohm_pkg.sv
rtl/ohm_ram.sv
rtl/ohm_hash.sv
rtl/ordered_hash_map_engine_top.sv
test/ordered_hash_map_engine_top_tb.sv
